FILE: rtl/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Shared widths, constants and types of the frame pixel statistics block.
// ----------------------------------------------------------------------------
package fps_pkg;

  // Payload widths of the channels.
  localparam int PIXEL_W     = 16;
  localparam int SIZE_W      = 11;
  localparam int CFG_INDEX_W = 8;
  localparam int NONZERO_W   = 21;
  localparam int CHANGE_W    = 20;
  localparam int ROWS_W      = 11;
  localparam int ROW_FIELD_W = 11;
  localparam int ROW_POS_W   = 10;
  localparam int SCORE_W     = 27;

  // Largest row number that the row fields can report.
  localparam int ROW_FIELD_MAX = 1023;

  // Score weights.
  localparam int ROW_WEIGHT  = 100000;
  localparam int RATE_WEIGHT = 1000;
  localparam int NZ_SHIFT    = 3;
  localparam int ROW_PROD_W  = 21;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  // Decoupling queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  // One classified pixel as it travels from the front to the back.
  typedef struct packed {
    logic [PIXEL_W-1:0]   pixel;
    logic                 first;
    logic                 end_of_row;
    logic                 end_of_frame;
    logic [ROW_POS_W-1:0] row;
  } fps_item_t;

  // Finished statistics of one frame.
  typedef struct packed {
    logic        [NONZERO_W-1:0]   nonzero;
    logic        [CHANGE_W-1:0]    change;
    logic        [ROWS_W-1:0]      rows;
    logic signed [ROW_FIELD_W-1:0] first_row;
    logic signed [ROW_FIELD_W-1:0] last_row;
    logic        [PIXEL_W-1:0]     first_value;
    logic        [PIXEL_W-1:0]     last_value;
  } fps_stats_t;

endpackage

FILE: rtl/fps_pixel_if.sv
// ----------------------------------------------------------------------------
// fps_pixel_if
// Pixel stream channel: valid, ready and one RGB565 pixel per beat.
// ----------------------------------------------------------------------------
interface fps_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [fps_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

FILE: rtl/fps_result_if.sv
// ----------------------------------------------------------------------------
// fps_result_if
// Result channel: valid, ready and the statistics of one frame per beat.
// ----------------------------------------------------------------------------
interface fps_result_if;
  logic                                    valid;
  logic                                    ready;
  logic        [fps_pkg::NONZERO_W-1:0]   nonzero_count;
  logic        [fps_pkg::CHANGE_W-1:0]    change_count;
  logic        [fps_pkg::ROWS_W-1:0]      rows_with_data;
  logic signed [fps_pkg::ROW_FIELD_W-1:0] first_data_row;
  logic signed [fps_pkg::ROW_FIELD_W-1:0] last_data_row;
  logic        [fps_pkg::PIXEL_W-1:0]     first_value;
  logic        [fps_pkg::PIXEL_W-1:0]     last_value;
  logic        [fps_pkg::SCORE_W-1:0]     quality_score;

  modport source (output valid, output nonzero_count, output change_count,
                  output rows_with_data, output first_data_row,
                  output last_data_row, output first_value, output last_value,
                  output quality_score, input ready);
  modport sink   (input valid, input nonzero_count, input change_count,
                  input rows_with_data, input first_data_row,
                  input last_data_row, input first_value, input last_value,
                  input quality_score, output ready);
endinterface

FILE: rtl/fps_cfg_if.sv
// ----------------------------------------------------------------------------
// fps_cfg_if
// Configuration write channel: valid, ready, register index and data.
// ----------------------------------------------------------------------------
interface fps_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fps_pkg::CFG_INDEX_W-1:0] index;
  logic [fps_pkg::SIZE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fps_front.sv
// ----------------------------------------------------------------------------
// fps_front
// Accepts pixels, tracks the raster position and tags each pixel as the
// first of a frame, the end of a row or the end of a frame.
// ----------------------------------------------------------------------------
module fps_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  fps_pixel_if.sink          in_if,
  fps_cfg_if.sink            cfg_if,
  output logic               push_valid,
  input  logic               push_ready,
  output fps_pkg::fps_item_t push_item,
  output logic               frame_clear
);
  import fps_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // Reset frame size, clamped to the supported maximum.
  localparam int WIDTH_RESET  = 320;
  localparam int HEIGHT_RESET = 240;
  localparam int WLAST_RESET  = ((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1;
  localparam int HLAST_RESET  = ((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET) - 1;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] wlast_r, wlast_nxt;
  logic [ROW_W-1:0] hlast_r, hlast_nxt;
  logic             in_beat;
  logic             cfg_beat;
  logic             end_of_row;
  logic             end_of_frame;

  assign cfg_if.ready = 1'b1;
  assign cfg_beat     = cfg_if.valid;
  assign in_if.ready  = push_ready;
  assign in_beat      = in_if.valid && push_ready;

  // A size write restarts the frame in progress.
  assign frame_clear = cfg_beat && (cfg_if.index == REG_FRAME_WIDTH ||
                                    cfg_if.index == REG_FRAME_HEIGHT);

  // Classify the current pixel from its position.
  assign end_of_row   = (col_r == wlast_r);
  assign end_of_frame = end_of_row && (row_r == hlast_r);

  always_comb begin
    push_item.pixel        = in_if.pixel;
    push_item.first        = (col_r == '0) && (row_r == '0);
    push_item.end_of_row   = end_of_row;
    push_item.end_of_frame = end_of_frame;
    if (32'(row_r) > ROW_FIELD_MAX) begin
      push_item.row = ROW_POS_W'(ROW_FIELD_MAX);
    end else begin
      push_item.row = ROW_POS_W'(row_r);
    end
  end
  assign push_valid = in_if.valid;

  // Size registers hold the last column and row index, clamped to range.
  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    if (cfg_beat && cfg_if.index == REG_FRAME_WIDTH) begin
      if (cfg_if.data == '0) begin
        wlast_nxt = '0;
      end else if (32'(cfg_if.data) >= MAX_WIDTH) begin
        wlast_nxt = COL_W'(MAX_WIDTH - 1);
      end else begin
        wlast_nxt = COL_W'(cfg_if.data - SIZE_W'(1));
      end
    end
    if (cfg_beat && cfg_if.index == REG_FRAME_HEIGHT) begin
      if (cfg_if.data == '0) begin
        hlast_nxt = '0;
      end else if (32'(cfg_if.data) >= MAX_HEIGHT) begin
        hlast_nxt = ROW_W'(MAX_HEIGHT - 1);
      end else begin
        hlast_nxt = ROW_W'(cfg_if.data - SIZE_W'(1));
      end
    end
  end

  // Raster position advances on every accepted beat.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (frame_clear) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_beat) begin
      if (end_of_row) begin
        col_nxt = '0;
        row_nxt = end_of_frame ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      wlast_r <= COL_W'(WLAST_RESET);
      hlast_r <= ROW_W'(HLAST_RESET);
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
    end
  end

endmodule

FILE: rtl/fps_queue.sv
// ----------------------------------------------------------------------------
// fps_queue
// Short first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module fps_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  fps_pkg::fps_item_t push_item,
  output logic               pop_valid,
  input  logic               pop,
  output fps_pkg::fps_item_t pop_item
);
  import fps_pkg::*;

  fps_item_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0]   count_r, count_nxt;
  logic                     do_push;
  logic                     do_pop;

  assign push_ready = (count_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QUEUE_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QUEUE_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QUEUE_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QUEUE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/fps_back.sv
// ----------------------------------------------------------------------------
// fps_back
// Accumulates the frame statistics and computes the quality score in a
// three-stage pipeline ending in the output register.
// ----------------------------------------------------------------------------
module fps_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               frame_clear,
  input  logic               pop_valid,
  output logic               pop,
  input  fps_pkg::fps_item_t pop_item,
  fps_result_if.source       out_if
);
  import fps_pkg::*;

  // Running accumulators.
  logic [NONZERO_W-1:0]          nz_r, nz_nxt;
  logic [CHANGE_W-1:0]           chg_r, chg_nxt;
  logic [ROWS_W-1:0]             rows_r, rows_nxt;
  logic signed [ROW_FIELD_W-1:0] first_row_r, first_row_nxt;
  logic signed [ROW_FIELD_W-1:0] last_row_r, last_row_nxt;
  logic [PIXEL_W-1:0]            first_pix_r, first_pix_nxt;
  logic [PIXEL_W-1:0]            prev_r, prev_nxt;
  logic                          row_data_r, row_data_nxt;

  // Pipeline stages.
  logic                   s1_v_r, s2_v_r, out_v_r;
  logic                   s1_ready, s2_ready, out_ready;
  fps_stats_t             stats, s1_r, s2_r;
  logic [SCORE_W-1:0]     s2_last_prod_r;
  logic [ROW_PROD_W-1:0]  s2_rows_prod_r;
  logic [ROW_POS_W-1:0]   last_pos;
  logic                   nonzero;
  logic                   row_data;

  assign out_ready = !out_v_r || out_if.ready;
  assign s2_ready  = !s2_v_r || out_ready;
  assign s1_ready  = !s1_v_r || s2_ready;

  // A frame-ending beat waits until the first stage has room.
  assign pop = pop_valid && (!pop_item.end_of_frame || s1_ready);

  assign nonzero  = (pop_item.pixel != '0);
  assign row_data = row_data_r || nonzero;

  // Update of the accumulators for the beat being popped.
  always_comb begin
    nz_nxt        = nz_r;
    chg_nxt       = chg_r;
    rows_nxt      = rows_r;
    first_row_nxt = first_row_r;
    last_row_nxt  = last_row_r;
    first_pix_nxt = first_pix_r;
    prev_nxt      = pop_item.pixel;
    row_data_nxt  = row_data;
    if (pop_item.first) begin
      first_pix_nxt = pop_item.pixel;
    end
    if (nonzero && nz_r != '1) begin
      nz_nxt = nz_r + NONZERO_W'(1);
    end
    if (!pop_item.first && pop_item.pixel != prev_r && chg_r != '1) begin
      chg_nxt = chg_r + CHANGE_W'(1);
    end
    if (pop_item.end_of_row) begin
      row_data_nxt = 1'b0;
      if (row_data) begin
        if (rows_r != '1) begin
          rows_nxt = rows_r + ROWS_W'(1);
        end
        if (first_row_r[ROW_FIELD_W-1]) begin
          first_row_nxt = ROW_FIELD_W'(pop_item.row);
        end
        last_row_nxt = ROW_FIELD_W'(pop_item.row);
      end
    end
  end

  // Snapshot of the finished frame.
  always_comb begin
    stats.nonzero     = nz_nxt;
    stats.change      = chg_nxt;
    stats.rows        = rows_nxt;
    stats.first_row   = first_row_nxt;
    stats.last_row    = last_row_nxt;
    stats.first_value = first_pix_nxt;
    stats.last_value  = pop_item.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || frame_clear || (pop && pop_item.end_of_frame)) begin
      nz_r        <= '0;
      chg_r       <= '0;
      rows_r      <= '0;
      first_row_r <= '1;
      last_row_r  <= '1;
      first_pix_r <= '0;
      prev_r      <= '0;
      row_data_r  <= 1'b0;
    end else if (pop) begin
      nz_r        <= nz_nxt;
      chg_r       <= chg_nxt;
      rows_r      <= rows_nxt;
      first_row_r <= first_row_nxt;
      last_row_r  <= last_row_nxt;
      first_pix_r <= first_pix_nxt;
      prev_r      <= prev_nxt;
      row_data_r  <= row_data_nxt;
    end
  end

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= pop && pop_item.end_of_frame;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // A missing last row weighs as row zero.
  assign last_pos = s1_r.last_row[ROW_FIELD_W-1] ? '0 : s1_r.last_row[ROW_POS_W-1:0];

  // Payload stages: snapshot, weight products, final sum.
  always_ff @(posedge clk) begin
    if (s1_ready && pop && pop_item.end_of_frame) begin
      s1_r <= stats;
    end
    if (s2_ready && s1_v_r) begin
      s2_r           <= s1_r;
      s2_last_prod_r <= SCORE_W'(last_pos) * SCORE_W'(ROW_WEIGHT);
      s2_rows_prod_r <= ROW_PROD_W'(s1_r.rows) * ROW_PROD_W'(RATE_WEIGHT);
    end
    if (out_ready && s2_v_r) begin
      out_if.nonzero_count  <= s2_r.nonzero;
      out_if.change_count   <= s2_r.change;
      out_if.rows_with_data <= s2_r.rows;
      out_if.first_data_row <= s2_r.first_row;
      out_if.last_data_row  <= s2_r.last_row;
      out_if.first_value    <= s2_r.first_value;
      out_if.last_value     <= s2_r.last_value;
      out_if.quality_score  <= s2_last_prod_r + SCORE_W'(s2_rows_prod_r)
                             + SCORE_W'(s2_r.change)
                             + SCORE_W'(s2_r.nonzero >> NZ_SHIFT);
    end
  end

  assign out_if.valid = out_v_r;

endmodule

FILE: rtl/frame_pixel_statistics.sv
// ----------------------------------------------------------------------------
// frame_pixel_statistics
// Per-frame statistics and quality score over a raster RGB565 pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one pixel per beat in raster order. out_if carries one
//   beat per completed frame, after the frame's final pixel: counts, first and
//   last data rows, first and last pixel and the quality score.
//   cfg_if writes frame_width (index 0) or frame_height (index 1); a write
//   clears the frame in progress and should be issued while the block is idle.
// Throughput: one pixel per cycle sustained while out_if takes results;
//   one-pixel frames too, and the back-end accumulators take a beat every cycle.
// Result path: a frame's last accepted pixel passes the queue entry, the
//   snapshot of the accumulators, the weight products, then the sum into the
//   output register.
// Reset: synchronous, active low; sizes return to 320 by 240 and counting
//   starts at row 0, column 0.
// Stall: a held result stalls the score pipeline; the four-entry queue fills
//   behind an end-of-frame pixel and in_if.ready drops. cfg_if is always ready.
// ----------------------------------------------------------------------------
module frame_pixel_statistics #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  fps_pixel_if.sink    in_if,
  fps_result_if.source out_if,
  fps_cfg_if.sink      cfg_if
);
  import fps_pkg::*;

  logic      push_valid;
  logic      push_ready;
  fps_item_t push_item;
  logic      pop_valid;
  logic      pop;
  fps_item_t pop_item;
  logic      frame_clear;

  // Position tracking and classification.
  fps_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .cfg_if      (cfg_if),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item),
    .frame_clear (frame_clear)
  );

  // Decoupling queue.
  fps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  // Accumulation and scoring.
  fps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_clear (frame_clear),
    .pop_valid   (pop_valid),
    .pop         (pop),
    .pop_item    (pop_item),
    .out_if      (out_if)
  );

endmodule
